// ===== sv/magic_length_tail_deframer_defines.svh =====
// assertion helpers for the deframer
`ifndef MAGIC_LENGTH_TAIL_DEFRAMER_DEFINES_SVH
`define MAGIC_LENGTH_TAIL_DEFRAMER_DEFINES_SVH

// same-cycle implication on the local clock and reset
`define MLTD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on the local clock and reset
`define MLTD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mltd_pkg.sv =====
package mltd_pkg;

    // default buffer depth in bytes
    localparam int DEF_BUF_BYTES = 64;

    // frame format
    localparam logic [7:0] HEAD_MAGIC = 8'hA5;
    localparam logic [7:0] TAIL_MAGIC = 8'hA7;
    localparam int         MIN_FRAME  = 6;
    localparam int         LEN_LO_OFF = 2;
    localparam int         LEN_HI_OFF = 3;
    localparam int         PAY_OFF    = 4;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SRCH  = 6'b000010,
        S_LEN   = 6'b000100,
        S_TAIL  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    // read phases of the header and tail checks
    typedef enum logic [2:0] {
        PH_ISSUE  = 3'b001,
        PH_SECOND = 3'b010,
        PH_EVAL   = 3'b100
    } t_phase;

endpackage

// ===== sv/mltd_ram.sv =====
module mltd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/magic_length_tail_deframer.sv =====
// Byte-stream deframer for frames of the form A5 A5, 16-bit little-endian total length,
// payload, A7 A7. Bytes sit in a circular buffer RAM of BUF_BYTES entries with a head
// pointer and a fill count. A byte that only extends the frame at the buffer front is taken
// without stalling the input. The byte that completes a frame with a good tail starts
// payload readout through the single RAM read port at one beat per cycle while the output
// is not stalled. A marker beat with byte_valid low stands for an empty payload. A bad
// length (below 6 or above BUF_BYTES) or a bad tail drops the two head bytes and rescans
// the buffer byte by byte through the same port, then reads the length and tail from the RAM;
// input is stalled meanwhile. The last result caused by a byte carries run_last and leaves
// once the scan for that byte ends, so the final beat of a frame is delivered at the end of
// its step. No clearing pass: the RAM needs no reset.
`include "magic_length_tail_deframer_defines.svh"

module magic_length_tail_deframer import mltd_pkg::*; #(
    parameter int BUF_BYTES = DEF_BUF_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_payload_byte,
    output logic       o_byte_valid,
    output logic       o_frame_first,
    output logic       o_frame_last,
    output logic       o_run_last
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam int FW = $clog2(BUF_BYTES + 1);

    localparam logic [AW:0]   BUF_A  = (AW + 1)'(BUF_BYTES);
    localparam logic [16:0]   BUF_L  = 17'(BUF_BYTES);
    localparam logic [15:0]   MIN_L  = 16'(MIN_FRAME);
    localparam logic [FW-1:0] MIN_F  = FW'(MIN_FRAME);
    localparam logic [FW-1:0] PAY_F  = FW'(PAY_OFF);
    localparam logic [AW-1:0] LO_A   = AW'(LEN_LO_OFF);
    localparam logic [AW-1:0] HI_A   = AW'(LEN_HI_OFF);
    localparam logic [FW-1:0] ZERO_F = '0;
    localparam logic [FW-1:0] ONE_F  = FW'(1);
    localparam logic [FW-1:0] TWO_F  = FW'(2);
    localparam logic [FW-1:0] THR_F  = FW'(3);
    localparam logic [FW-1:0] FOUR_F = FW'(4);

    // buffer index with wrap, offset always below twice the depth
    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= BUF_A) begin
            s = s - BUF_A;
        end
        return s[AW-1:0];
    endfunction

    // sequencer and buffer state
    t_state        r_state, n_state;
    t_phase        r_ph, n_ph;
    logic [AW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_total, n_total;
    logic [FW-1:0] r_idx, n_idx;
    logic [FW-1:0] r_em_off, n_em_off;
    logic          r_prev_a5, n_prev_a5;
    logic          r_tail_ok, n_tail_ok;
    logic [7:0]    r_lo, n_lo;
    logic [7:0]    r_prev_rx, n_prev_rx;

    // read stage tags
    logic r_rd_v, n_rd_v;
    logic r_rd_first, n_rd_first;
    logic r_rd_last, n_rd_last;

    // pending beat and output register
    logic       r_pd_v;
    logic [7:0] r_pd_byte;
    logic       r_pd_bv, r_pd_first, r_pd_last;
    logic       r_out_v;
    logic [7:0] r_out_byte;
    logic       r_out_bv, r_out_first, r_out_last, r_out_run;

    // ram ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // flow control
    logic          out_free, pd_take, marker, em_issue, consume, mark_push, push;
    logic          em_done, move;
    logic [FW-1:0] em_end;
    logic [7:0]    p_byte;
    logic          p_bv, p_first, p_last;

    mltd_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_stall   = (r_state != S_IDLE);
    assign out_free  = !r_out_v || !i_stall;
    assign pd_take   = !r_pd_v || out_free;
    assign em_end    = r_total - TWO_F;
    assign marker    = (r_total == MIN_F);
    assign em_issue  = (r_state == S_EMIT) && !marker && (r_em_off != em_end)
                       && (!r_rd_v || pd_take);
    assign consume   = r_rd_v && pd_take;
    assign mark_push = (r_state == S_EMIT) && marker && pd_take;
    assign push      = consume || mark_push;
    assign em_done   = (r_state == S_EMIT) && !marker && (r_em_off == em_end)
                       && (!r_rd_v || consume);
    assign move      = r_pd_v && out_free && (push || (r_state == S_FLUSH));

    // beat entering the pending slot
    always_comb begin
        if (mark_push) begin
            p_byte  = 8'h00;
            p_bv    = 1'b0;
            p_first = 1'b1;
            p_last  = 1'b1;
        end else begin
            p_byte  = rd_data;
            p_bv    = 1'b1;
            p_first = r_rd_first;
            p_last  = r_rd_last;
        end
    end

    // sequencer: fast path on arrival, rescan and readout over the ram
    always_comb begin
        logic [15:0]   len16;
        logic [FW-1:0] fill_inc;
        logic [FW-1:0] skip;
        logic          drop2;
        logic          drop_frame;
        logic          start_emit;

        n_state    = r_state;
        n_ph       = r_ph;
        n_head     = r_head;
        n_fill     = r_fill;
        n_total    = r_total;
        n_idx      = r_idx;
        n_em_off   = r_em_off;
        n_prev_a5  = r_prev_a5;
        n_tail_ok  = r_tail_ok;
        n_lo       = r_lo;
        n_prev_rx  = r_prev_rx;
        n_rd_v     = r_rd_v;
        n_rd_first = r_rd_first;
        n_rd_last  = r_rd_last;
        wr_en      = 1'b0;
        wr_addr    = wrap(r_head, r_fill[AW-1:0]);
        rd_en      = 1'b0;
        rd_addr    = r_head;
        len16      = {rd_data, r_lo};
        fill_inc   = r_fill + ONE_F;
        skip       = r_idx - ONE_F;
        drop2      = 1'b0;
        drop_frame = 1'b0;
        start_emit = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    wr_en     = 1'b1;
                    n_prev_rx = i_rx_byte;
                    len16     = {i_rx_byte, r_prev_rx};
                    if (r_fill == ZERO_F) begin
                        n_fill = (i_rx_byte == HEAD_MAGIC) ? ONE_F : ZERO_F;
                    end else if (r_fill == ONE_F) begin
                        n_fill = (i_rx_byte == HEAD_MAGIC) ? TWO_F : ZERO_F;
                    end else if (r_fill == TWO_F) begin
                        n_fill = THR_F;
                    end else if (r_fill == THR_F) begin
                        if ((len16 < MIN_L) || (17'(len16) > BUF_L)) begin
                            n_fill = FOUR_F;
                            drop2  = 1'b1;
                        end else begin
                            n_fill  = FOUR_F;
                            n_total = len16[FW-1:0];
                        end
                    end else begin
                        n_fill = fill_inc;
                        if (fill_inc == r_total) begin
                            if ((r_prev_rx == TAIL_MAGIC) && (i_rx_byte == TAIL_MAGIC)) begin
                                start_emit = 1'b1;
                            end else begin
                                drop2 = 1'b1;
                            end
                        end
                    end
                end
            end
            S_SRCH: begin
                if (r_ph == PH_ISSUE) begin
                    rd_en   = 1'b1;
                    rd_addr = wrap(r_head, r_idx[AW-1:0]);
                    n_ph    = PH_SECOND;
                end else if (r_prev_a5 && (rd_data == HEAD_MAGIC)) begin
                    // head found one byte back
                    n_head = wrap(r_head, skip[AW-1:0]);
                    n_fill = r_fill - skip;
                    n_ph   = PH_ISSUE;
                    n_state = (n_fill < FOUR_F) ? S_FLUSH : S_LEN;
                end else if ((r_idx + ONE_F) == r_fill) begin
                    // no head: keep a trailing A5 only
                    if (rd_data == HEAD_MAGIC) begin
                        n_head = wrap(r_head, skip[AW-1:0] + AW'(1));
                        n_fill = ONE_F;
                    end else begin
                        n_fill = ZERO_F;
                    end
                    n_state = S_FLUSH;
                end else begin
                    n_prev_a5 = (rd_data == HEAD_MAGIC);
                    n_idx     = r_idx + ONE_F;
                    n_ph      = PH_ISSUE;
                end
            end
            S_LEN: begin
                case (r_ph)
                    PH_ISSUE: begin
                        rd_en   = 1'b1;
                        rd_addr = wrap(r_head, LO_A);
                        n_ph    = PH_SECOND;
                    end
                    PH_SECOND: begin
                        n_lo    = rd_data;
                        rd_en   = 1'b1;
                        rd_addr = wrap(r_head, HI_A);
                        n_ph    = PH_EVAL;
                    end
                    default: begin
                        if ((len16 < MIN_L) || (17'(len16) > BUF_L)) begin
                            drop2 = 1'b1;
                        end else begin
                            n_total = len16[FW-1:0];
                            n_ph    = PH_ISSUE;
                            n_state = (17'(r_fill) < 17'(len16)) ? S_FLUSH : S_TAIL;
                        end
                    end
                endcase
            end
            S_TAIL: begin
                case (r_ph)
                    PH_ISSUE: begin
                        rd_en   = 1'b1;
                        rd_addr = wrap(r_head, em_end[AW-1:0]);
                        n_ph    = PH_SECOND;
                    end
                    PH_SECOND: begin
                        n_tail_ok = (rd_data == TAIL_MAGIC);
                        rd_en     = 1'b1;
                        rd_addr   = wrap(r_head, em_end[AW-1:0] + AW'(1));
                        n_ph      = PH_EVAL;
                    end
                    default: begin
                        if (r_tail_ok && (rd_data == TAIL_MAGIC)) begin
                            start_emit = 1'b1;
                        end else begin
                            drop2 = 1'b1;
                        end
                    end
                endcase
            end
            S_EMIT: begin
                if (marker) begin
                    drop_frame = pd_take;
                end else begin
                    if (em_issue) begin
                        rd_en      = 1'b1;
                        rd_addr    = wrap(r_head, r_em_off[AW-1:0]);
                        n_em_off   = r_em_off + ONE_F;
                        n_rd_v     = 1'b1;
                        n_rd_first = (r_em_off == PAY_F);
                        n_rd_last  = ((r_em_off + ONE_F) == em_end);
                    end else if (consume) begin
                        n_rd_v = 1'b0;
                    end
                    drop_frame = em_done;
                end
            end
            S_FLUSH: begin
                if (pd_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // drop the two head bytes and rescan
        if (drop2) begin
            n_head    = wrap(r_head, TWO_F[AW-1:0]);
            n_fill    = n_fill - TWO_F;
            n_idx     = ZERO_F;
            n_prev_a5 = 1'b0;
            n_ph      = PH_ISSUE;
            n_state   = S_SRCH;
        end

        // payload readout of a checked frame
        if (start_emit) begin
            n_em_off = PAY_F;
            n_rd_v   = 1'b0;
            n_ph     = PH_ISSUE;
            n_state  = S_EMIT;
        end

        // frame delivered, remove it from the buffer
        if (drop_frame) begin
            n_head    = wrap(r_head, r_total[AW-1:0]);
            n_fill    = r_fill - r_total;
            n_idx     = ZERO_F;
            n_prev_a5 = 1'b0;
            n_ph      = PH_ISSUE;
            n_state   = (n_fill == ZERO_F) ? S_FLUSH : S_SRCH;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= PH_ISSUE;
            r_head  <= '0;
            r_fill  <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_rd_v  <= n_rd_v;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_total    <= n_total;
        r_idx      <= n_idx;
        r_em_off   <= n_em_off;
        r_prev_a5  <= n_prev_a5;
        r_tail_ok  <= n_tail_ok;
        r_lo       <= n_lo;
        r_prev_rx  <= n_prev_rx;
        r_rd_first <= n_rd_first;
        r_rd_last  <= n_rd_last;
    end

    // pending beat: held until the next beat or the end of the step decides run_last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pd_v <= 1'b0;
        end else if (push) begin
            r_pd_v <= 1'b1;
        end else if (move) begin
            r_pd_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_pd_byte  <= p_byte;
            r_pd_bv    <= p_bv;
            r_pd_first <= p_first;
            r_pd_last  <= p_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_free) begin
            r_out_v <= move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_byte  <= r_pd_byte;
            r_out_bv    <= r_pd_bv;
            r_out_first <= r_pd_first;
            r_out_last  <= r_pd_last;
            r_out_run   <= !push;
        end
    end

    assign o_valid        = r_out_v;
    assign o_payload_byte = r_out_byte;
    assign o_byte_valid   = r_out_bv;
    assign o_frame_first  = r_out_first;
    assign o_frame_last   = r_out_last;
    assign o_run_last     = r_out_run;

    // checks
    `MLTD_ASSERT_IMP(a_idle_no_pending, (r_state == S_IDLE), !r_pd_v,
                     "pending beat left over at end of step")
    `MLTD_ASSERT_IMP(a_read_stage_in_emit, r_rd_v, (r_state == S_EMIT),
                     "payload read outstanding outside readout")
    `MLTD_ASSERT_IMP(a_partial_frame, ((r_state == S_IDLE) && (r_fill >= FOUR_F)),
                     (r_fill < r_total), "buffered frame not shorter than its length")
    `MLTD_ASSERT_NXT(a_flush_ends_step, ((r_state == S_FLUSH) && move),
                     (r_state == S_IDLE), "step did not end after final beat")

endmodule

// ===== tb/tb_magic_length_tail_deframer.sv =====
`timescale 1ns / 100ps

module tb_magic_length_tail_deframer;
    import mltd_pkg::*;

    localparam int BUF_BYTES = DEF_BUF_BYTES;

    // defects injected into generated frames
    typedef enum int {
        FL_NONE,
        FL_TAIL,
        FL_LEN,
        FL_CUT
    } t_flaw;

    // one expected output beat
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       frame_first;
        logic       frame_last;
        logic       run_last;
    } t_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_payload_byte;
    logic       o_byte_valid;
    logic       o_frame_first;
    logic       o_frame_last;
    logic       o_run_last;

    // deframer model state
    logic [7:0] rx_buf [BUF_BYTES];
    int         rx_fill;
    t_beat      frame_beats [$];

    int n_errors;
    int n_sent;
    int stall_left;
    bit idle_on;

    magic_length_tail_deframer #(
        .BUF_BYTES(BUF_BYTES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_payload_byte(o_payload_byte),
        .o_byte_valid  (o_byte_valid),
        .o_frame_first (o_frame_first),
        .o_frame_last  (o_frame_last),
        .o_run_last    (o_run_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run time limit
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // discard bytes at the front of the model buffer
    function automatic void drop_front(input int n);
        int k;
        if (n >= rx_fill) begin
            rx_fill = 0;
        end else begin
            for (k = 0; k < rx_fill - n; k++) rx_buf[k] = rx_buf[k + n];
            rx_fill -= n;
        end
    endfunction

    function automatic void push_beat(input logic [7:0] b, input logic bv,
                                      input logic first, input logic last);
        t_beat beat;
        beat.payload_byte = b;
        beat.byte_valid   = bv;
        beat.frame_first  = first;
        beat.frame_last   = last;
        beat.run_last     = 1'b0;
        frame_beats.insert(frame_beats.size(), beat);
    endfunction

    // append one byte and extract every frame it completes
    function automatic void deframe_byte(input logic [7:0] b);
        int    pos;
        int    total;
        int    plen;
        int    n_out;
        t_beat beat;
        n_out = 0;
        if (rx_fill < BUF_BYTES) begin
            rx_buf[rx_fill] = b;
            rx_fill++;
        end
        while (1'b1) begin
            pos = rx_fill;
            for (int i = 0; i + 1 < rx_fill; i++) begin
                if (rx_buf[i] == HEAD_MAGIC && rx_buf[i + 1] == HEAD_MAGIC) begin
                    pos = i;
                    break;
                end
            end
            // no head: keep only a trailing half head
            if (pos == rx_fill) begin
                if (rx_fill > 0 && rx_buf[rx_fill - 1] == HEAD_MAGIC) begin
                    rx_buf[0] = HEAD_MAGIC;
                    rx_fill   = 1;
                end else begin
                    rx_fill = 0;
                end
                break;
            end
            drop_front(pos);
            if (rx_fill < 4) break;
            total = {rx_buf[LEN_HI_OFF], rx_buf[LEN_LO_OFF]};
            if (total < MIN_FRAME || total > BUF_BYTES) begin
                drop_front(2);
                continue;
            end
            if (rx_fill < total) break;
            if (rx_buf[total - 2] != TAIL_MAGIC || rx_buf[total - 1] != TAIL_MAGIC) begin
                drop_front(2);
                continue;
            end
            // good frame: payload beats or one empty marker
            plen = total - MIN_FRAME;
            if (plen == 0) begin
                push_beat(8'h00, 1'b0, 1'b1, 1'b1);
                n_out++;
            end else begin
                for (int k = 0; k < plen; k++) begin
                    push_beat(rx_buf[PAY_OFF + k], 1'b1, k == 0, k + 1 == plen);
                    n_out++;
                end
            end
            drop_front(total);
        end
        // mark the last beat of this byte
        if (n_out > 0) begin
            beat = frame_beats[frame_beats.size() - 1];
            beat.run_last = 1'b1;
            frame_beats[frame_beats.size() - 1] = beat;
        end
    endfunction

    // receiver stall bursts
    initial begin
        stall_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!idle_on) stall_left = 0;
            else if (stall_left > 0) stall_left--;
            else if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 19);
            i_stall <= (stall_left > 0);
        end
    end

    // output beat checker
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (frame_beats.size() == 0) begin
                $error("unexpected output beat, payload_byte %02h", o_payload_byte);
                n_errors++;
            end else begin
                want = frame_beats.pop_front();
                if (o_payload_byte !== want.payload_byte) begin
                    $error("payload_byte expected %02h actual %02h",
                           want.payload_byte, o_payload_byte);
                    n_errors++;
                end
                if (o_byte_valid !== want.byte_valid) begin
                    $error("byte_valid expected %0b actual %0b",
                           want.byte_valid, o_byte_valid);
                    n_errors++;
                end
                if (o_frame_first !== want.frame_first) begin
                    $error("frame_first expected %0b actual %0b",
                           want.frame_first, o_frame_first);
                    n_errors++;
                end
                if (o_frame_last !== want.frame_last) begin
                    $error("frame_last expected %0b actual %0b",
                           want.frame_last, o_frame_last);
                    n_errors++;
                end
                if (o_run_last !== want.run_last) begin
                    $error("run_last expected %0b actual %0b",
                           want.run_last, o_run_last);
                    n_errors++;
                end
            end
        end
    end

    // send one beat, with an optional gap before it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        deframe_byte(b);
        n_sent++;
    endtask

    // build a frame around a random payload, optionally damaged
    task automatic send_frame(input int plen, input t_flaw flaw);
        logic [7:0] fr [$];
        int         total;
        int         cut;
        total = plen + MIN_FRAME;
        if (flaw == FL_LEN) begin
            total = $urandom_range(0, 1) ? $urandom_range(0, MIN_FRAME - 1)
                                         : $urandom_range(BUF_BYTES + 1, 65535);
        end
        fr.insert(fr.size(), HEAD_MAGIC);
        fr.insert(fr.size(), HEAD_MAGIC);
        fr.insert(fr.size(), total[7:0]);
        fr.insert(fr.size(), total[15:8]);
        for (int k = 0; k < plen; k++) fr.insert(fr.size(), 8'($urandom_range(0, 255)));
        fr.insert(fr.size(), TAIL_MAGIC);
        fr.insert(fr.size(), TAIL_MAGIC);
        if (flaw == FL_TAIL) begin
            fr[fr.size() - 1 - $urandom_range(0, 1)] = $urandom_range(0, 1) ? HEAD_MAGIC
                                                                          : 8'h00;
        end
        cut = fr.size();
        if (flaw == FL_CUT) cut = $urandom_range(1, fr.size() - 1);
        for (int k = 0; k < cut; k++) send_byte(fr[k]);
    endtask

    // random noise, rich in head bytes
    task automatic send_noise(input int n);
        for (int k = 0; k < n; k++) begin
            send_byte($urandom_range(0, 3) == 0 ? HEAD_MAGIC : 8'($urandom_range(0, 255)));
        end
    endtask

    function automatic int pick_plen();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(13, BUF_BYTES - MIN_FRAME)
                                            : $urandom_range(0, 12);
    endfunction

    // frame with empty payload gives one marker beat
    task automatic test_empty_frame();
        send_byte(HEAD_MAGIC);
        send_byte(HEAD_MAGIC);
        send_byte(8'd6);
        send_byte(8'h00);
        send_byte(TAIL_MAGIC);
        send_byte(TAIL_MAGIC);
    endtask

    // junk byte, then a frame with a one-byte payload
    task automatic test_lone_head();
        send_byte(8'h00);
        send_byte(HEAD_MAGIC);
        send_byte(HEAD_MAGIC);
        send_byte(8'd7);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(TAIL_MAGIC);
        send_byte(TAIL_MAGIC);
    endtask

    // length below minimum drops the head
    task automatic test_short_length();
        send_byte(HEAD_MAGIC);
        send_byte(HEAD_MAGIC);
        send_byte(8'd5);
        send_byte(8'h00);
    endtask

    // wrong tail drops the head and rescans
    task automatic test_bad_tail();
        send_byte(HEAD_MAGIC);
        send_byte(HEAD_MAGIC);
        send_byte(8'd7);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(TAIL_MAGIC);
        send_byte(8'hA6);
    endtask

    // largest frame, oversize lengths and magic inside the payload
    task automatic test_long_frames();
        send_frame(BUF_BYTES - MIN_FRAME, FL_NONE);
        send_byte(HEAD_MAGIC);
        send_byte(HEAD_MAGIC);
        send_byte(8'(BUF_BYTES + 1));
        send_byte(8'h00);
        send_noise(3);
        send_byte(HEAD_MAGIC);
        send_byte(HEAD_MAGIC);
        send_byte(8'h06);
        send_byte(8'h01);
        send_byte(HEAD_MAGIC);
        send_byte(HEAD_MAGIC);
        send_byte(8'd10);
        send_byte(8'h00);
        send_byte(HEAD_MAGIC);
        send_byte(HEAD_MAGIC);
        send_byte(TAIL_MAGIC);
        send_byte(TAIL_MAGIC);
        send_byte(TAIL_MAGIC);
        send_byte(TAIL_MAGIC);
        // incomplete frame later overtaken by a good one through rescan
        send_frame(4, FL_CUT);
        send_frame(3, FL_NONE);
    endtask

    // mostly well-formed frames with damaged ones and noise between
    task automatic test_random_stream(input int n_items);
        int pick;
        int stop_at;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      send_frame(pick_plen(), FL_NONE);
            else if (pick < 80) send_frame(pick_plen(), FL_TAIL);
            else if (pick < 87) send_frame(pick_plen(), FL_LEN);
            else if (pick < 92) send_frame(pick_plen(), FL_CUT);
            else                send_noise($urandom_range(1, 5));
        end
    endtask

    // back to back frames with no idling on either side
    task automatic test_steady_stream();
        idle_on = 1'b0;
        for (int k = 0; k < 6; k++) send_frame($urandom_range(0, 8), FL_NONE);
        send_frame($urandom_range(0, 8), FL_TAIL);
        send_frame($urandom_range(0, 8), FL_NONE);
    endtask

    // main sequence
    initial begin
        n_errors  = 0;
        n_sent    = 0;
        rx_fill   = 0;
        idle_on   = 1'b1;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_rx_byte <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_frame();
        test_lone_head();
        test_short_length();
        test_bad_tail();
        test_long_frames();
        test_random_stream(270);
        test_steady_stream();

        // drain remaining beats
        i_valid <= 1'b0;
        while (frame_beats.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (frame_beats.size() != 0) begin
            $error("%0d expected beats never arrived", frame_beats.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
